[design/irpd_pkg.sv]
// Shared types, constants and packet framing for the IR pad transmitter.
package irpd_pkg;

    localparam int unsigned WORD_BITS = 16;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [5:0]           bits_t;
    typedef logic [15:0]          gap_t;

    // Command codes on s_cmd
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Configuration register indexes
    localparam logic [3:0] REG_START_GAP = 4'd0;
    localparam logic [3:0] REG_ZERO_GAP  = 4'd1;
    localparam logic [3:0] REG_ONE_GAP   = 4'd2;
    localparam logic [3:0] REG_STOP_GAP  = 4'd3;

    // Register reset values (tenths of the nominal tick counts)
    localparam gap_t START_GAP_RST = gap_t'(2815 / 10);
    localparam gap_t ZERO_GAP_RST  = gap_t'(1023 / 10);
    localparam gap_t ONE_GAP_RST   = gap_t'(1919 / 10);
    localparam gap_t STOP_GAP_RST  = gap_t'(5503 / 10);

    // Bit counter codes: full word at packet start, stop phase marker
    localparam bits_t BITS_FULL = bits_t'(WORD_BITS);
    localparam bits_t STOP_MARK = 6'd63;

    localparam word_t PLAYER_ONE_BIT = word_t'(1 << 6);

    // Build the packet: player bit, then XOR of the upper nibbles into the low nibble
    function automatic word_t frame_word(input word_t buttons, input logic first_player);
        word_t w;
        logic [3:0] chk;
        w   = buttons | (first_player ? PLAYER_ONE_BIT : '0);
        chk = w[15:12] ^ w[11:8] ^ w[7:4];
        return w | {12'b0, chk};
    endfunction

endpackage

[design/ir_pad_pulse_distance_tx.sv]
// Top level of the pulse-distance IR gamepad transmitter.
//
//  Channel   Direction  Ports                                         Moves
//  s_        in         s_cmd, s_first_player, s_buttons              tick or update request
//  m_        out        m_irq_pulse, m_packet_dropped, m_queue_level  one result per request
//  cfg_      in         cfg_index, cfg_wdata                          gap register write
//
// One request per cycle while s_ready is high: each request updates the FIFO and
// transmitter state in the cycle it is accepted and its result is registered at the same edge.
// s_ready is high whenever the result register is empty or being drained.
// The packet word is read from the FIFO array at the pop edge and used from that
// registered read port until the first bit gap shifts it into the shift register.
// Reset (aresetn low, synchronous) empties the FIFO and idles the transmitter; no
// clearing pass is needed. cfg_ready is always high.
module ir_pad_pulse_distance_tx
    import irpd_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 16,
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  logic             s_first_player,
    input  logic [15:0]      s_buttons,

    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_irq_pulse,
    output logic             m_packet_dropped,
    output logic [CNT_W-1:0] m_queue_level,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [3:0]       cfg_index,
    input  logic [15:0]      cfg_wdata
);

    // Gap registers
    gap_t start_gap_reg, zero_gap_reg, one_gap_reg, stop_gap_reg;

    // Transmitter state
    logic  sending_reg, sending_next;
    bits_t bits_left_reg, bits_left_next;
    gap_t  gap_timer_reg, gap_timer_next;
    word_t shift_word_reg, shift_word_next;
    logic  from_fifo_reg, from_fifo_next;

    // Result register
    logic             m_valid_reg;
    logic             irq_reg, irq_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] level_reg, level_next;

    // FIFO hookup
    logic             push, pop;
    word_t            fifo_rd;
    logic [CNT_W-1:0] fifo_count;
    logic             fifo_full, fifo_empty;
    word_t            cur_word;
    logic             accept;

    irpd_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (frame_word(s_buttons, s_first_player)),
        .pop       (pop),
        .rd_data   (fifo_rd),
        .count     (fifo_count),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Word being sent: straight from the FIFO read port until the first shift
    assign cur_word = from_fifo_reg ? fifo_rd : shift_word_reg;

    // Request processing
    always_comb begin
        push            = 1'b0;
        pop             = 1'b0;
        irq_next        = 1'b0;
        dropped_next    = 1'b0;
        sending_next    = sending_reg;
        bits_left_next  = bits_left_reg;
        gap_timer_next  = gap_timer_reg;
        shift_word_next = shift_word_reg;
        from_fifo_next  = from_fifo_reg;
        if (accept) begin
            if (s_cmd == CMD_UPDATE) begin
                if (fifo_full) begin
                    dropped_next = 1'b1;
                end else begin
                    push = 1'b1;
                end
            end else if (!sending_reg) begin
                if (!fifo_empty) begin
                    pop            = 1'b1;
                    sending_next   = 1'b1;
                    bits_left_next = BITS_FULL;
                    gap_timer_next = start_gap_reg;
                    from_fifo_next = 1'b1;
                    irq_next       = 1'b1;
                end
            end else if (gap_timer_reg != '0) begin
                gap_timer_next = gap_timer_reg - 1'b1;
            end else begin
                irq_next = 1'b1;
                if (bits_left_reg == STOP_MARK) begin
                    sending_next   = 1'b0;
                    bits_left_next = '0;
                end else if (bits_left_reg != '0) begin
                    gap_timer_next  = cur_word[WORD_BITS-1] ? one_gap_reg : zero_gap_reg;
                    shift_word_next = {cur_word[WORD_BITS-2:0], 1'b0};
                    from_fifo_next  = 1'b0;
                    bits_left_next  = bits_left_reg - 1'b1;
                end else begin
                    gap_timer_next = stop_gap_reg;
                    bits_left_next = STOP_MARK;
                end
            end
        end
    end

    // Queue level after this request
    always_comb begin
        level_next = fifo_count;
        if (push) begin
            level_next = fifo_count + 1'b1;
        end else if (pop) begin
            level_next = fifo_count - 1'b1;
        end
    end

    // Transmitter state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg    <= 1'b0;
            bits_left_reg  <= '0;
            gap_timer_reg  <= '0;
            shift_word_reg <= '0;
            from_fifo_reg  <= 1'b0;
        end else begin
            sending_reg    <= sending_next;
            bits_left_reg  <= bits_left_next;
            gap_timer_reg  <= gap_timer_next;
            shift_word_reg <= shift_word_next;
            from_fifo_reg  <= from_fifo_next;
        end
    end

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_gap_reg <= START_GAP_RST;
            zero_gap_reg  <= ZERO_GAP_RST;
            one_gap_reg   <= ONE_GAP_RST;
            stop_gap_reg  <= STOP_GAP_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_GAP: start_gap_reg <= cfg_wdata;
                REG_ZERO_GAP:  zero_gap_reg  <= cfg_wdata;
                REG_ONE_GAP:   one_gap_reg   <= cfg_wdata;
                REG_STOP_GAP:  stop_gap_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            irq_reg     <= irq_next;
            dropped_reg <= dropped_next;
            level_reg   <= level_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_irq_pulse      = irq_reg;
    assign m_packet_dropped = dropped_reg;
    assign m_queue_level    = level_reg;

endmodule

[design/irpd_fifo.sv]
// Packet FIFO: register array, head/tail pointers, fill count, registered read on pop.
module irpd_fifo
    import irpd_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 16,
    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  word_t            push_data,
    input  logic             pop,
    output word_t            rd_data,
    output logic [CNT_W-1:0] count,
    output logic             full,
    output logic             empty
);

    word_t            mem [FIFO_DEPTH];
    word_t            rd_data_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer advance with wrap at the configured depth
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        head_next  = pop  ? advance(head_reg) : head_reg;
        tail_next  = push ? advance(tail_reg) : tail_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_data;
        end
        if (pop) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;
    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);

endmodule

[design/irpd_checker.sv]
// Port-level checker for the IR pad transmitter, bound to the top level.
module irpd_checker #(
    parameter int unsigned FIFO_DEPTH = 16,
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_irq_pulse,
    input logic             m_packet_dropped,
    input logic [CNT_W-1:0] m_queue_level
);

    // A tick never drops, an update never interrupts
    a_irq_drop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_irq_pulse && m_packet_dropped))
        else $error("irq and drop flagged on one result");

    // A drop only happens with a full queue
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_packet_dropped) |-> (m_queue_level == CNT_W'(FIFO_DEPTH)))
        else $error("drop reported with room in the queue");

    // Level never exceeds depth
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_queue_level <= CNT_W'(FIFO_DEPTH)))
        else $error("queue level beyond depth");

    // An accepted request always produces a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted request without result");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_irq_pulse)
            && $stable(m_packet_dropped) && $stable(m_queue_level)))
        else $error("stalled result changed");

endmodule

bind ir_pad_pulse_distance_tx irpd_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_irpd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_irq_pulse      (m_irq_pulse),
    .m_packet_dropped (m_packet_dropped),
    .m_queue_level    (m_queue_level)
);
